### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the search core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/tls_pkg.sv
// ----------------------------------------------------------------------------
// Lower-bound search package
// Element type codes, order-key mapping and shared control struct.
// ----------------------------------------------------------------------------
package tls_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam logic [3:0] T_INT8   = 4'd0;
    localparam logic [3:0] T_INT16  = 4'd1;
    localparam logic [3:0] T_INT32  = 4'd2;
    localparam logic [3:0] T_INT64  = 4'd3;
    localparam logic [3:0] T_UINT8  = 4'd4;
    localparam logic [3:0] T_UINT16 = 4'd5;
    localparam logic [3:0] T_UINT32 = 4'd6;
    localparam logic [3:0] T_UINT64 = 4'd7;
    localparam logic [3:0] T_FP32   = 4'd8;
    localparam logic [3:0] T_FP64   = 4'd9;

    localparam logic [0:0] CFG_TYPE  = 1'b0;
    localparam logic [0:0] CFG_COUNT = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic valid;
        logic kind;
        logic eq;
    } t_ctl;

    // NaNs map to zero, both zeros map to the sign position, negatives are
    // inverted and positives get the sign bit set.
    function automatic logic [31:0] f_key32(logic [31:0] b);
        logic [31:0] k;
        if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
            k = 32'd0;
        end else if (b[30:0] == 31'd0) begin
            k = 32'h8000_0000;
        end else if (b[31]) begin
            k = ~b;
        end else begin
            k = b | 32'h8000_0000;
        end
        return k;
    endfunction

    function automatic logic [63:0] f_key64(logic [63:0] b);
        logic [63:0] k;
        if (b[62:52] == 11'h7FF && b[51:0] != 52'd0) begin
            k = 64'd0;
        end else if (b[62:0] == 63'd0) begin
            k = 64'h8000_0000_0000_0000;
        end else if (b[63]) begin
            k = ~b;
        end else begin
            k = b | 64'h8000_0000_0000_0000;
        end
        return k;
    endfunction

    function automatic logic [63:0] f_key(logic [63:0] raw, logic [3:0] typ);
        logic [63:0] k;
        case (typ)
            T_INT8:   k = {56'd0, ~raw[7], raw[6:0]};
            T_INT16:  k = {48'd0, ~raw[15], raw[14:0]};
            T_INT32:  k = {32'd0, ~raw[31], raw[30:0]};
            T_INT64:  k = {~raw[63], raw[62:0]};
            T_UINT8:  k = {56'd0, raw[7:0]};
            T_UINT16: k = {48'd0, raw[15:0]};
            T_UINT32: k = {32'd0, raw[31:0]};
            T_FP32:   k = {32'd0, f_key32(raw[31:0])};
            T_FP64:   k = f_key64(raw);
            default:  k = raw;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/tls_level.sv
// ----------------------------------------------------------------------------
// Search level
// One halving step: own copy of the table, a read stage and a compare stage.
// ----------------------------------------------------------------------------
module tls_level #(
    parameter int DEPTH = tls_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [3:0]                  i_type,
    input  tls_pkg::t_ctl               i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_idx,
    input  logic [63:0]                 i_val,
    input  logic [$clog2(DEPTH+1)-1:0]  i_lo,
    input  logic [$clog2(DEPTH+1)-1:0]  i_hi,
    input  logic [63:0]                 i_tgt,
    output tls_pkg::t_ctl               o_ctl,
    output logic [$clog2(DEPTH)-1:0]    o_idx,
    output logic [63:0]                 o_val,
    output logic [$clog2(DEPTH+1)-1:0]  o_lo,
    output logic [$clog2(DEPTH+1)-1:0]  o_hi,
    output logic [63:0]                 o_tgt
);
    import tls_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH+1);

    logic [63:0]   r_mem [DEPTH];
    logic [63:0]   r_rd;
    t_ctl          r_ctl;
    logic          r_act;
    logic [IW-1:0] r_idx;
    logic [63:0]   r_val;
    logic [PW-1:0] r_lo, r_hi, r_mid;
    logic [63:0]   r_tgt;

    t_ctl          r_o_ctl;
    logic [IW-1:0] r_o_idx;
    logic [63:0]   r_o_val;
    logic [PW-1:0] r_o_lo, r_o_hi;
    logic [63:0]   r_o_tgt;

    logic [PW:0]   w_sum;
    logic [PW-1:0] w_mid;
    logic          w_act;
    logic [63:0]   w_key;
    logic          w_lt;
    t_ctl          n_ctl;
    logic [PW-1:0] n_lo, n_hi;

    assign w_sum = {1'b0, i_lo} + {1'b0, i_hi};
    assign w_mid = w_sum[PW:1];
    assign w_act = i_ctl.valid && (i_ctl.kind == KIND_SEARCH) && (i_lo < i_hi);

    // Write items update this level's copy in stream order with the searches.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctl.valid && (i_ctl.kind == KIND_WRITE)
                && ({1'b0, i_idx} < PW'(DEPTH))) begin
                r_mem[i_idx] <= i_val;
            end
            r_rd <= r_mem[w_mid[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act <= w_act;
            r_idx <= i_idx;
            r_val <= i_val;
            r_lo  <= i_lo;
            r_hi  <= i_hi;
            r_mid <= w_mid;
            r_tgt <= i_tgt;
        end
    end

    assign w_key = f_key(r_rd, i_type);
    assign w_lt  = w_key < r_tgt;

    // The eq flag always describes the element at the current upper bound.
    always_comb begin
        n_ctl = r_ctl;
        n_lo  = r_lo;
        n_hi  = r_hi;
        if (r_act) begin
            if (w_lt) begin
                n_lo = r_mid + PW'(1);
            end else begin
                n_hi     = r_mid;
                n_ctl.eq = (w_key == r_tgt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_ctl <= '0;
        end else if (i_en) begin
            r_o_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_idx <= r_idx;
            r_o_val <= r_val;
            r_o_lo  <= n_lo;
            r_o_hi  <= n_hi;
            r_o_tgt <= r_tgt;
        end
    end

    assign o_ctl = r_o_ctl;
    assign o_idx = r_o_idx;
    assign o_val = r_o_val;
    assign o_lo  = r_o_lo;
    assign o_hi  = r_o_hi;
    assign o_tgt = r_o_tgt;

endmodule

### rtl/core/typed_lower_bound_search_top.sv
// ----------------------------------------------------------------------------
// Typed lower-bound search
// Sorted table loaded word by word; searches return the lower bound position.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tuser: kind; tdata: entry_index, entry_value, search_value
//  m_axis    | out       | tdata: position, found (searches only)
//  cfg       | in        | index 0 element_type, index 1 table_count
//
// A word enters every cycle unless the pipeline is frozen. A search passes the entry
// stage, one read stage and one compare stage per halving level, each level reading
// its own table copy, and the output stage. Writes reach every copy in stream order.
// The whole pipeline freezes while a result waits on m_axis_tready.
// Reset is synchronous, active low, clears valid bits and table_count, sets int64 type.
// ----------------------------------------------------------------------------
module typed_lower_bound_search_top #(
    parameter int TABLE_DEPTH = tls_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: entry_index, entry_value, search_value (low bit up), zero pad
    input  logic [(($clog2(TABLE_DEPTH)+128+7)/8)*8-1:0] s_axis_tdata,
    // tuser: kind
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: position, found (low bit up), zero pad
    output logic [(($clog2(TABLE_DEPTH+1)+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [(($clog2(TABLE_DEPTH+1) > 4) ? $clog2(TABLE_DEPTH+1) : 4)-1:0] i_cfg_data
);
    import tls_pkg::*;

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int PW     = $clog2(TABLE_DEPTH+1);
    localparam int LEVELS = IW + 1;
    localparam int CDW    = (PW > 4) ? PW : 4;
    localparam int OW     = ((PW + 1 + 7) / 8) * 8;

    logic [3:0]    r_type;
    logic [PW-1:0] r_count;
    logic          w_en;
    logic          w_last_srch;

    t_ctl          s_ctl [LEVELS+1];
    logic [IW-1:0] s_idx [LEVELS+1];
    logic [63:0]   s_val [LEVELS+1];
    logic [PW-1:0] s_lo  [LEVELS+1];
    logic [PW-1:0] s_hi  [LEVELS+1];
    logic [63:0]   s_tgt [LEVELS+1];

    t_ctl          r_e_ctl;
    logic [IW-1:0] r_e_idx;
    logic [63:0]   r_e_val;
    logic [PW-1:0] r_e_hi;
    logic [63:0]   r_e_tgt;

    logic          r_out_valid;
    logic [PW-1:0] r_out_pos;
    logic          r_out_found;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= T_INT64;
            r_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TYPE:  r_type <= i_cfg_data[3:0];
                CFG_COUNT: begin
                    if ({1'b0, i_cfg_data} > (CDW+1)'(TABLE_DEPTH)) begin
                        r_count <= PW'(TABLE_DEPTH);
                    end else begin
                        r_count <= i_cfg_data[PW-1:0];
                    end
                end
                default: r_type <= r_type;
            endcase
        end
    end

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl <= '0;
        end else if (w_en) begin
            r_e_ctl.valid <= s_axis_tvalid;
            r_e_ctl.kind  <= s_axis_tuser;
            r_e_ctl.eq    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_idx <= s_axis_tdata[IW-1:0];
            r_e_val <= s_axis_tdata[IW+63:IW];
            r_e_hi  <= r_count;
            r_e_tgt <= f_key(s_axis_tdata[IW+127:IW+64], r_type);
        end
    end

    assign s_ctl[0] = r_e_ctl;
    assign s_idx[0] = r_e_idx;
    assign s_val[0] = r_e_val;
    assign s_lo[0]  = '0;
    assign s_hi[0]  = r_e_hi;
    assign s_tgt[0] = r_e_tgt;

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        tls_level #(.DEPTH(TABLE_DEPTH)) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_type  (r_type),
            .i_ctl   (s_ctl[g]),
            .i_idx   (s_idx[g]),
            .i_val   (s_val[g]),
            .i_lo    (s_lo[g]),
            .i_hi    (s_hi[g]),
            .i_tgt   (s_tgt[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_idx   (s_idx[g+1]),
            .o_val   (s_val[g+1]),
            .o_lo    (s_lo[g+1]),
            .o_hi    (s_hi[g+1]),
            .o_tgt   (s_tgt[g+1])
        );
    end

    assign w_last_srch = s_ctl[LEVELS].valid && (s_ctl[LEVELS].kind == KIND_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last_srch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pos   <= s_lo[LEVELS];
            r_out_found <= s_ctl[LEVELS].eq;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OW-PW-1)'(0), r_out_found, r_out_pos};

`include "assert_macros.svh"

    // A finished search has closed its interval.
    `TLS_ASSERT_IMP(a_closed, i_clk, i_rst_n, w_last_srch, s_lo[LEVELS] == s_hi[LEVELS])
    // A hit always lies below the table size.
    `TLS_ASSERT_IMP(a_found_in_range, i_clk, i_rst_n, r_out_valid && r_out_found, r_out_pos < PW'(TABLE_DEPTH))
    // An accepted search word shows up in the entry stage.
    `TLS_ASSERT_NXT(a_entry, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, r_e_ctl.valid && r_e_ctl.kind)

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lower-bound search testbench
// Loads sorted tables of random element types, runs directed and random searches
// and checks every returned position and found flag against a local predictor.
// ----------------------------------------------------------------------------
module tb;
    import tls_pkg::*;

    localparam int DEPTH    = 1024;
    localparam int SDW      = ((10 + 128 + 7) / 8) * 8;
    localparam int MDW      = ((11 + 1 + 7) / 8) * 8;
    localparam int LAT      = 2 * (10 + 1) + 2;
    localparam int WDOG     = 20000;
    localparam int HOLD_LEN = 300;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [SDW-1:0]  s_axis_tdata = '0;
    logic            s_axis_tuser = 1'b0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [MDW-1:0]  m_axis_tdata;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [0:0]      i_cfg_index = '0;
    logic [10:0]     i_cfg_data = '0;

    typedef struct packed {
        logic [10:0] position;
        logic        found;
    } t_lookup;

    logic [63:0] table_model [DEPTH];
    logic [3:0]  cur_type;
    logic [10:0] cur_count;
    t_lookup     lookup_queue [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        long_hold = 1'b0;
    int          hold_cnt = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    logic        failed = 1'b0;

    always #5 i_clk = ~i_clk;

    typed_lower_bound_search_top #(.TABLE_DEPTH(DEPTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Maps a raw element to an unsigned key whose order is the element order.
    function automatic logic [63:0] sort_key(logic [63:0] raw, logic [3:0] typ);
        logic [63:0] key;
        logic [31:0] s;
        case (typ)
            T_INT8:   key = {56'd0, raw[7:0] ^ 8'h80};
            T_INT16:  key = {48'd0, raw[15:0] ^ 16'h8000};
            T_INT32:  key = {32'd0, raw[31:0] ^ 32'h8000_0000};
            T_INT64:  key = raw ^ 64'h8000_0000_0000_0000;
            T_UINT8:  key = {56'd0, raw[7:0]};
            T_UINT16: key = {48'd0, raw[15:0]};
            T_UINT32: key = {32'd0, raw[31:0]};
            T_FP32: begin
                s = raw[31:0];
                if (&s[30:23] && |s[22:0]) key = 64'd0;
                else if (s[30:0] == 0) key = 64'h8000_0000;
                else if (s[31]) key = {32'd0, ~s};
                else key = {32'd0, s | 32'h8000_0000};
            end
            T_FP64: begin
                if (&raw[62:52] && |raw[51:0]) key = 64'd0;
                else if (raw[62:0] == 0) key = 64'h8000_0000_0000_0000;
                else if (raw[63]) key = ~raw;
                else key = raw | 64'h8000_0000_0000_0000;
            end
            default:  key = raw;
        endcase
        return key;
    endfunction

    function automatic t_lookup lower_bound(logic [63:0] target_raw);
        int n, lo, hi, mid;
        logic [63:0] target;
        t_lookup r;
        n = (cur_count > DEPTH) ? DEPTH : cur_count;
        target = sort_key(target_raw, cur_type);
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (sort_key(table_model[mid], cur_type) < target) lo = mid + 1;
            else hi = mid;
        end
        r.position = lo[10:0];
        r.found = (lo < n) && (sort_key(table_model[lo], cur_type) == target);
        return r;
    endfunction

    task automatic send_word(logic kind, logic [9:0] idx, logic [63:0] ev, logic [63:0] sv);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {{(SDW - 138){1'b0}}, sv, ev, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_WRITE) table_model[idx] = ev;
        else lookup_queue.push_back(lower_bound(sv));
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (lookup_queue.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [10:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TYPE) cur_type = val[3:0];
        else cur_count = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random value of the given type, with a bias toward edge values.
    function automatic logic [63:0] pick_value(logic [3:0] typ);
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(9, 0))
            0: v = '0;
            1: v = '1;
            2: v = (typ == T_FP32) ? 64'h7FC0_0000 : 64'h7FF8_0000_0000_0001;
            3: v = (typ == T_FP32) ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
            4: v = 64'($urandom_range(3, 0));
            default: ;
        endcase
        return v;
    endfunction

    // Loads n random elements sorted by key, written in random order.
    task automatic load_sorted(int n);
        logic [63:0] vals [$];
        logic [63:0] tmp;
        int order [$];
        for (int i = 0; i < n; i++) vals.push_back(pick_value(cur_type));
        for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && sort_key(vals[j-1], cur_type) >
                 sort_key(vals[j], cur_type); j--) begin
                tmp = vals[j];
                vals[j] = vals[j-1];
                vals[j-1] = tmp;
            end
        for (int i = 0; i < n; i++) order.push_back(i);
        order.shuffle();
        foreach (order[k]) send_word(KIND_WRITE, order[k][9:0], vals[order[k]], rand64());
    endtask

    task automatic search_mix(int cnt, int n);
        int k;
        for (int i = 0; i < cnt; i++) begin
            if (n > 0 && $urandom_range(2, 0) == 0) begin
                k = $urandom_range(n - 1, 0);
                send_word(KIND_SEARCH, 10'($urandom()), rand64(), table_model[k]);
            end else begin
                send_word(KIND_SEARCH, 10'($urandom()), rand64(), pick_value(cur_type));
            end
        end
    endtask

    task automatic test_directed();
        int n;
        write_cfg(CFG_TYPE, 11'(T_INT64));
        write_cfg(CFG_COUNT, 11'd0);
        send_word(KIND_SEARCH, 10'h3FF, '1, 64'h1234);
        // Fill the whole table with ascending values so that every read is defined.
        for (int i = 0; i < DEPTH; i++)
            send_word(KIND_WRITE, i[9:0], 64'(i * 2) - 64'd600, '1);
        quiesce();
        write_cfg(CFG_COUNT, 11'd1024);
        send_word(KIND_SEARCH, '0, '0, 64'h8000_0000_0000_0000);
        send_word(KIND_SEARCH, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(KIND_SEARCH, '0, '0, 64'd0);
        send_word(KIND_SEARCH, '0, '0, 64'd1);
        send_word(KIND_SEARCH, '0, '0, 64'(-600));
        send_word(KIND_SEARCH, '0, '0, 64'd1446);
        quiesce();
        // Counts above the depth are clamped.
        write_cfg(CFG_COUNT, 11'd2047);
        send_word(KIND_SEARCH, '0, '0, 64'd2000);
        quiesce();
        write_cfg(CFG_TYPE, 11'd15);
        write_cfg(CFG_COUNT, 11'd1);
        send_word(KIND_SEARCH, '0, '0, '1);
        send_word(KIND_SEARCH, '0, '0, '0);
        quiesce();
        write_cfg(CFG_TYPE, 11'(T_FP64));
        n = 4;
        send_word(KIND_WRITE, 10'd0, 64'h7FF8_0000_0000_0000, '0);
        send_word(KIND_WRITE, 10'd1, 64'hBFF0_0000_0000_0000, '0);
        send_word(KIND_WRITE, 10'd2, 64'h8000_0000_0000_0000, '0);
        send_word(KIND_WRITE, 10'd3, 64'h3FF0_0000_0000_0000, '0);
        quiesce();
        write_cfg(CFG_COUNT, n[10:0]);
        send_word(KIND_SEARCH, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(KIND_SEARCH, '0, '0, 64'h0000_0000_0000_0000);
        send_word(KIND_SEARCH, '0, '0, 64'h7FF0_0000_0000_0000);
        send_word(KIND_SEARCH, '0, '0, 64'hFFF0_0000_0000_0000);
        // Unsorted contents: the answer is whatever the halving steps give.
        send_word(KIND_WRITE, 10'd1, 64'h4000_0000_0000_0000, '0);
        send_word(KIND_SEARCH, '0, '0, 64'h3FF0_0000_0000_0000);
        quiesce();
    endtask

    task automatic test_random_types(int rounds);
        int n;
        for (int r = 0; r < rounds; r++) begin
            write_cfg(CFG_TYPE, 11'($urandom_range(15, 0)));
            n = $urandom_range(12, 1);
            load_sorted(n);
            quiesce();
            write_cfg(CFG_COUNT, 11'($urandom_range(n, 0)));
            search_mix(14, int'(cur_count));
            quiesce();
        end
    endtask

    task automatic test_backpressure();
        write_cfg(CFG_TYPE, 11'(T_UINT16));
        load_sorted(16);
        quiesce();
        write_cfg(CFG_COUNT, 11'd16);
        long_hold = 1'b1;
        search_mix(120, 16);
        quiesce();
        long_hold = 1'b0;
    endtask

    // Receiver stall generator, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (long_hold && hold_cnt < HOLD_LEN) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (!long_hold) hold_cnt <= 0;
            m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_lookup got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[10:0], m_axis_tdata[11]};
            if (lookup_queue.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
            end else begin
                want = lookup_queue.pop_front();
                if (got.position !== want.position || got.found !== want.found) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: position %0d found %0d, expected %0d %0d",
                                 got.position, got.found, want.position, want.found);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_type = T_INT64;
        cur_count = '0;
        for (int i = 0; i < DEPTH; i++) table_model[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_types(6);
        send_idle_pct = 81;
        test_random_types(8);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        test_random_types(8);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        test_random_types(6);
        test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_types(4);
        quiesce();
        if (!failed && lookup_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
